// File: hw/rtl/utf8d_pkg.sv
// Types and constants shared by the UTF-8 stream decoder.
// No dependencies.
package utf8d_pkg;

  localparam int unsigned CpWidth  = 31;
  localparam int unsigned RemWidth = 3;

  // Byte ranges of ASCII and of the lead bytes of the two- to six-byte forms
  localparam logic [7:0] ASCII_MAX  = 8'd127;
  localparam logic [7:0] LEAD2_MIN  = 8'd192;
  localparam logic [7:0] LEAD2_MAX  = 8'd223;
  localparam logic [7:0] LEAD3_MIN  = 8'd224;
  localparam logic [7:0] LEAD3_MAX  = 8'd239;
  localparam logic [7:0] LEAD4_MIN  = 8'd240;
  localparam logic [7:0] LEAD4_MAX  = 8'd247;
  localparam logic [7:0] LEAD5_MIN  = 8'd248;
  localparam logic [7:0] LEAD5_MAX  = 8'd251;
  localparam logic [7:0] LEAD6_MIN  = 8'd252;
  localparam logic [7:0] LEAD6_MAX  = 8'd253;

  typedef logic [CpWidth-1:0]  cp_t;
  typedef logic [RemWidth-1:0] rem_t;

  typedef struct packed {
    cp_t  partial_value;
    rem_t bytes_remaining;
  } dec_state_t;

  typedef struct packed {
    logic emit;
    logic has_char;
    logic end_of_text;
    cp_t  code_point;
  } step_res_t;

endpackage

// File: hw/rtl/utf8d_if.sv
// Valid/ready channels for raw bytes in and decoded characters out.
// Depends on utf8d_pkg for the code point type.
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface utf8d_char_if;
  logic            valid;
  logic            ready;
  utf8d_pkg::cp_t  code_point;
  logic            has_char;
  logic            end_of_text;

  modport source (output valid, code_point, has_char, end_of_text, input ready);
  modport sink   (input valid, code_point, has_char, end_of_text, output ready);
endinterface

// File: hw/rtl/utf8d_step.sv
// Per-byte decode step: next sequence state and the result of one byte.
// Depends on utf8d_pkg.
module utf8d_step
  import utf8d_pkg::*;
(
  input  dec_state_t cur,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output dec_state_t nxt,
  output step_res_t  res
);

  logic got;
  cp_t  cp;
  cp_t  shifted;

  assign shifted = {cur.partial_value[CpWidth-7:0], data_byte[5:0]};

  always_comb begin
    nxt = cur;
    got = 1'b0;
    cp  = '0;
    priority if (cur.bytes_remaining != '0) begin
      // open sequence: any byte counts as continuation
      nxt.partial_value   = shifted;
      nxt.bytes_remaining = cur.bytes_remaining - rem_t'(1);
      if (cur.bytes_remaining == rem_t'(1)) begin
        got               = 1'b1;
        cp                = shifted;
        nxt.partial_value = '0;
      end
    end else if (data_byte <= ASCII_MAX) begin
      got = 1'b1;
      cp  = cp_t'(data_byte);
    end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
      nxt.partial_value   = cp_t'(data_byte[4:0]);
      nxt.bytes_remaining = rem_t'(1);
    end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
      nxt.partial_value   = cp_t'(data_byte[3:0]);
      nxt.bytes_remaining = rem_t'(2);
    end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
      nxt.partial_value   = cp_t'(data_byte[2:0]);
      nxt.bytes_remaining = rem_t'(3);
    end else if (data_byte >= LEAD5_MIN && data_byte <= LEAD5_MAX) begin
      nxt.partial_value   = cp_t'(data_byte[1:0]);
      nxt.bytes_remaining = rem_t'(4);
    end else if (data_byte >= LEAD6_MIN && data_byte <= LEAD6_MAX) begin
      nxt.partial_value   = cp_t'(data_byte[0]);
      nxt.bytes_remaining = rem_t'(5);
    end else begin
      // stray continuation or 254/255: skipped
      nxt = cur;
    end

    if (last_byte) begin
      nxt = '0;
    end

    res.emit        = got | last_byte;
    res.has_char    = got;
    res.end_of_text = last_byte;
    res.code_point  = got ? cp : '0;
  end

endmodule

// File: hw/rtl/utf8_stream_decoder.sv
// A byte's result is registered and appears in the cycle after its transfer.
// Throughput: one byte per cycle; the sequence state register closes a
// loop through the combinational decode step. The input stalls only while a
// result waits and the receiver is not ready.
// Reset (synchronous, active high) closes any open sequence and drops
// the pending result.
module utf8_stream_decoder
  import utf8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  utf8d_byte_if.sink         bytes,
  utf8d_char_if.source       chars
);

  dec_state_t state;
  dec_state_t state_next;
  step_res_t  res;
  logic       in_xfer;

  logic out_valid;
  cp_t  code_point;
  logic has_char;
  logic end_of_text;

  utf8d_step u_step (
    .cur       (state),
    .data_byte (bytes.data_byte),
    .last_byte (bytes.last_byte),
    .nxt       (state_next),
    .res       (res)
  );

  assign bytes.ready = !out_valid || chars.ready;
  assign in_xfer     = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      state     <= state_next;
      out_valid <= res.emit;
    end else if (chars.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res.emit) begin
      code_point  <= res.code_point;
      has_char    <= res.has_char;
      end_of_text <= res.end_of_text;
    end
  end

  assign chars.valid       = out_valid;
  assign chars.code_point  = code_point;
  assign chars.has_char    = has_char;
  assign chars.end_of_text = end_of_text;

`ifndef SYNTHESIS
  a_last_closes_seq: assert property (@(posedge clk) disable iff (rst)
    in_xfer && bytes.last_byte |=> state.bytes_remaining == '0 && state.partial_value == '0)
    else $error("sequence still open after last byte");

  a_last_gives_end: assert property (@(posedge clk) disable iff (rst)
    in_xfer && bytes.last_byte |=> out_valid && end_of_text)
    else $error("last byte gave no end-of-text result");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> code_point == '0 && end_of_text)
    else $error("result without character is malformed");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state.bytes_remaining <= rem_t'(5))
    else $error("bytes_remaining out of range");
`endif

endmodule
